@@ design/pwdt_pkg.sv @@
// Shared types and constants for the prescaled watchdog timer.
package pwdt_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } pwdt_op_e;

  localparam logic [7:0]  OFF_CONTROL = 8'h00;
  localparam logic [7:0]  OFF_RELOAD  = 8'h04;
  localparam logic [7:0]  OFF_COUNT   = 8'h08;

  localparam logic [31:0] CTRL_RESET_VAL   = 32'h0000_8021;
  localparam logic [31:0] RELOAD_RESET_VAL = 32'h0000_8000;
  localparam logic [31:0] COUNT_RESET_VAL  = 32'h0000_8000;
  localparam logic [31:0] UNKNOWN_RD_VAL   = 32'hFFFF_FFFF;

  // control register fields
  localparam int unsigned CTRL_RST_EN_BIT = 0;
  localparam int unsigned CTRL_IRQ_EN_BIT = 2;
  localparam int unsigned CTRL_DIV_LSB    = 3;
  localparam int unsigned CTRL_ENABLE_BIT = 5;
  localparam int unsigned CTRL_PRE_LSB    = 8;
  localparam int unsigned PRE_W           = 8;
  localparam int unsigned BASE_DIV_SHIFT  = 4;  // base divide of 16

  localparam int unsigned PRESCALE_W = 16;

  typedef struct packed {
    pwdt_op_e    opcode;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } pwdt_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        reset_pulse;
  } pwdt_rsp_t;

endpackage

@@ design/pwdt_core.sv @@
// Watchdog register file, prescaler and count update for one item.
module pwdt_core import pwdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  pwdt_req_t req_i,
  output pwdt_rsp_t rsp_o
);

  logic [31:0]           control_q, control_d;
  logic [31:0]           reload_q, reload_d;
  logic [31:0]           count_q, count_d;
  logic [PRESCALE_W-1:0] prescale_q, prescale_d;

  logic [PRE_W:0]        pre_plus1;
  logic [1:0]            div_sel;
  logic [PRESCALE_W-1:0] interval;
  logic [PRESCALE_W-1:0] prescale_inc;
  logic [31:0]           count_next;

  // interval = (prescaler + 1) * (16 << divider), a pure shift
  assign pre_plus1    = {1'b0, control_q[CTRL_PRE_LSB +: PRE_W]} + {{PRE_W{1'b0}}, 1'b1};
  assign div_sel      = control_q[CTRL_DIV_LSB +: 2];
  assign interval     = PRESCALE_W'({{(PRESCALE_W-PRE_W-1){1'b0}}, pre_plus1}
                        << (BASE_DIV_SHIFT + 32'(div_sel)));
  assign prescale_inc = prescale_q + {{(PRESCALE_W-1){1'b0}}, 1'b1};
  assign count_next   = (count_q == 32'd0) ? reload_q : count_q - 32'd1;

  always_comb begin
    control_d  = control_q;
    reload_d   = reload_q;
    count_d    = count_q;
    prescale_d = prescale_q;
    rsp_o      = '0;
    unique case (req_i.opcode)
      OP_TICK: begin
        if (control_q[CTRL_ENABLE_BIT]) begin
          if (prescale_inc >= interval) begin
            prescale_d = '0;
            count_d    = count_next;
            if (count_next == 32'd0) begin
              rsp_o.irq_pulse   = control_q[CTRL_IRQ_EN_BIT];
              rsp_o.reset_pulse = control_q[CTRL_RST_EN_BIT];
              if (control_q[CTRL_RST_EN_BIT]) begin
                control_d  = CTRL_RESET_VAL;
                reload_d   = RELOAD_RESET_VAL;
                count_d    = COUNT_RESET_VAL;
                prescale_d = '0;
              end
            end
          end else begin
            prescale_d = prescale_inc;
          end
        end
      end
      OP_READ: begin
        unique case (req_i.reg_offset)
          OFF_CONTROL: rsp_o.read_data = control_q;
          OFF_RELOAD:  rsp_o.read_data = reload_q;
          OFF_COUNT:   rsp_o.read_data = count_q;
          default:     rsp_o.read_data = UNKNOWN_RD_VAL;
        endcase
      end
      OP_WRITE: begin
        unique case (req_i.reg_offset)
          OFF_CONTROL: begin
            control_d  = req_i.write_data;
            prescale_d = '0;
          end
          OFF_RELOAD:  reload_d = req_i.write_data;
          OFF_COUNT: begin
            count_d    = req_i.write_data;
            prescale_d = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= CTRL_RESET_VAL;
      reload_q   <= RELOAD_RESET_VAL;
      count_q    <= COUNT_RESET_VAL;
      prescale_q <= '0;
    end else if (step_i) begin
      control_q  <= control_d;
      reload_q   <= reload_d;
      count_q    <= count_d;
      prescale_q <= prescale_d;
    end
  end

endmodule

@@ design/prescaled_watchdog_timer.sv @@
// Top level of the prescaled watchdog timer: input and result registers.
// Each transfer on the input channel is one peripheral clock tick, a register
// read, a register write or a no-op, and gives exactly one result. While the
// output is not stalled the block sustains one item per cycle: items land in an
// input register, the register file and prescaler are updated in the same
// cycle that moves an item into the result register, and the result is then
// offered from the result register. A stalled result holds while one more item
// waits in the input register.
module prescaled_watchdog_timer import pwdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  reg_offset_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_pulse_o,
  output logic        reset_pulse_o
);

  logic      req_valid_q;
  pwdt_req_t req_q;
  logic      rsp_valid_q;
  pwdt_rsp_t rsp_q;
  pwdt_rsp_t rsp_d;
  logic      step;

  assign step       = req_valid_q && (!rsp_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (step) begin
        rsp_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.opcode     <= pwdt_op_e'(opcode_i);
      req_q.reg_offset <= reg_offset_i;
      req_q.write_data <= write_data_i;
    end
    if (step) begin
      rsp_q <= rsp_d;
    end
  end

  pwdt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  assign out_valid_o   = rsp_valid_q;
  assign read_data_o   = rsp_q.read_data;
  assign irq_pulse_o   = rsp_q.irq_pulse;
  assign reset_pulse_o = rsp_q.reset_pulse;

endmodule

@@ design/pwdt_checker.sv @@
// Port-level assertions for the prescaled watchdog timer, bound to the top.
module pwdt_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic        irq_pulse_o,
  input logic        reset_pulse_o
);

  // a pulse only comes from a tick, which reads nothing
  a_pulse_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (irq_pulse_o || reset_pulse_o) |-> read_data_o == 32'd0)
    else $error("pulse result carries read data");

  // input side only blocks when the result register is full
  a_ready_blocks_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(irq_pulse_o) && $stable(reset_pulse_o))
    else $error("stalled result changed");

endmodule

bind prescaled_watchdog_timer pwdt_port_checker u_pwdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .read_data_o   (read_data_o),
  .irq_pulse_o   (irq_pulse_o),
  .reset_pulse_o (reset_pulse_o)
);
